// ----- hdl/pcs_pkg.sv -----
`timescale 1ns / 1ps

package pcs_pkg;

    localparam logic [31:0] TYPE_IDAT = 32'h5441_4449;
    localparam logic [31:0] TYPE_ACTL = 32'h4C54_6361;
    localparam logic [31:0] TYPE_FCTL = 32'h4C54_6366;
    localparam logic [31:0] TYPE_FDAT = 32'h5441_6466;
    localparam logic [31:0] TYPE_NPTC = 32'h6354_706E;
    localparam logic [31:0] TYPE_TRNS = 32'h534E_5274;
    localparam logic [31:0] TYPE_ICCP = 32'h5043_4369;
    localparam logic [31:0] TYPE_IEND = 32'h444E_4549;

    localparam int          ANCILLARY_BIT = 5;
    localparam logic [32:0] CRC_BYTES     = 33'd4;
    localparam int          HDR_BYTES     = 8;
    localparam logic [2:0]  HDR_LAST_IDX  = 3'd7;

    // One queue entry: up to eight output bytes, emitted data[0] .. data[last_idx].
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] data;
        logic [2:0]                last_idx;
        logic                      file_end;
    } entry_t;

endpackage

// ----- hdl/png_ancillary_chunk_stripper.sv -----
`timescale 1ns / 1ps

// Strips most ancillary chunks from a PNG byte stream. One byte is accepted per
// cycle while the request queue has room; the front holds each 8-byte chunk
// header, classifies the chunk and queues its output bytes; the back sends them
// one byte per cycle while m_ready is high. A kept header goes out as eight bytes,
// so the sustained rate is one byte per cycle, set by the single output byte lane;
// input stalls only while QUEUE_DEPTH requests wait. No clearing pass after reset.
module png_ancillary_chunk_stripper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last,
    output logic       m_out_file_end
);

    logic            push;
    pcs_pkg::entry_t push_entry;
    logic            full;
    logic            head_valid;
    pcs_pkg::entry_t head;
    logic            pop;

    assign s_ready = !full;

    pcs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (s_valid && s_ready),
        .in_byte     (s_in_byte),
        .in_last     (s_in_last),
        .push        (push),
        .push_entry  (push_entry)
    );

    pcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pcs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_last     (m_out_last),
        .m_out_file_end (m_out_file_end)
    );

endmodule

// ----- hdl/pcs_front.sv -----
`timescale 1ns / 1ps

module pcs_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          push,
    output pcs_pkg::entry_t push_entry
);

    typedef enum logic [3:0] {
        PH_SIG  = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic [7:0]  hold_reg [pcs_pkg::HDR_BYTES];
    logic [7:0]  hold_next [pcs_pkg::HDR_BYTES];
    logic [32:0] brem_reg, brem_next;
    logic        idat_seen_reg, idat_seen_next;
    logic        keep_reg, keep_next;
    logic        is_end_reg, is_end_next;
    logic        keep_icc_reg;

    logic [31:0] type_word;
    logic [31:0] chunk_len;
    logic        chunk_keep;
    logic [32:0] brem_dec;

    assign chunk_len  = {hold_reg[0], hold_reg[1], hold_reg[2], hold_reg[3]};
    assign type_word  = {in_byte, hold_reg[6], hold_reg[5], hold_reg[4]};
    assign brem_dec   = brem_reg - {32'd0, (brem_reg != 33'd0)};

    always_comb begin
        if (!type_word[pcs_pkg::ANCILLARY_BIT]) begin
            chunk_keep = 1'b1;
        end else begin
            unique case (type_word) inside
                pcs_pkg::TYPE_ACTL, pcs_pkg::TYPE_FCTL,
                pcs_pkg::TYPE_FDAT, pcs_pkg::TYPE_NPTC: chunk_keep = 1'b1;
                pcs_pkg::TYPE_TRNS: chunk_keep = !idat_seen_reg;
                pcs_pkg::TYPE_ICCP: chunk_keep = keep_icc_reg;
                default:            chunk_keep = 1'b0;
            endcase
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        hpos_next      = hpos_reg;
        hold_next      = hold_reg;
        brem_next      = brem_reg;
        idat_seen_next = idat_seen_reg;
        keep_next      = keep_reg;
        is_end_next    = is_end_reg;
        push           = 1'b0;
        push_entry     = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_SIG: begin
                    push                = 1'b1;
                    push_entry.data[0]  = in_byte;
                    push_entry.file_end = in_last;
                    if (hpos_reg == 4'd7) begin
                        phase_next = PH_HDR;
                        hpos_next  = 4'd0;
                    end else begin
                        hpos_next = hpos_reg + 4'd1;
                    end
                end
                PH_HDR: begin
                    hold_next[hpos_reg[2:0]] = in_byte;
                    hpos_next                = hpos_reg + 4'd1;
                    for (int i = 0; i < pcs_pkg::HDR_BYTES; i++) begin
                        push_entry.data[i] = (3'(i) == hpos_reg[2:0]) ? in_byte : hold_reg[i];
                    end
                    if (in_last) begin
                        // early end: flush what is held
                        push                = 1'b1;
                        push_entry.last_idx = hpos_reg[2:0];
                        push_entry.file_end = 1'b1;
                    end else if (hpos_reg == 4'd7) begin
                        hpos_next   = 4'd0;
                        phase_next  = PH_BODY;
                        brem_next   = {1'b0, chunk_len} + pcs_pkg::CRC_BYTES;
                        is_end_next = (type_word == pcs_pkg::TYPE_IEND);
                        keep_next   = chunk_keep;
                        if (type_word == pcs_pkg::TYPE_IDAT) begin
                            idat_seen_next = 1'b1;
                        end
                        push                = chunk_keep;
                        push_entry.last_idx = pcs_pkg::HDR_LAST_IDX;
                    end
                end
                PH_BODY: begin
                    brem_next           = brem_dec;
                    push                = keep_reg;
                    push_entry.data[0]  = in_byte;
                    push_entry.file_end = ((brem_dec == 33'd0) && is_end_reg) || in_last;
                    if (brem_dec == 33'd0) begin
                        phase_next = is_end_reg ? PH_DONE : PH_HDR;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            if (in_last) begin
                phase_next     = PH_SIG;
                hpos_next      = 4'd0;
                brem_next      = '0;
                idat_seen_next = 1'b0;
                keep_next      = 1'b0;
                is_end_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIG;
            hpos_reg      <= '0;
            brem_reg      <= '0;
            idat_seen_reg <= 1'b0;
            keep_reg      <= 1'b0;
            is_end_reg    <= 1'b0;
            keep_icc_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hpos_reg      <= hpos_next;
            brem_reg      <= brem_next;
            idat_seen_reg <= idat_seen_next;
            keep_reg      <= keep_next;
            is_end_reg    <= is_end_next;
            if (cfg_wr_en) begin
                keep_icc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

endmodule

// ----- hdl/pcs_queue.sv -----
`timescale 1ns / 1ps

module pcs_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pcs_pkg::entry_t push_entry,
    output logic            full,
    output logic            head_valid,
    output pcs_pkg::entry_t head,
    input  logic            pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    pcs_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_MAX);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/pcs_back.sv -----
`timescale 1ns / 1ps

module pcs_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  pcs_pkg::entry_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last,
    output logic            m_out_file_end
);

    logic [2:0] idx_reg, idx_next;
    logic       at_end;

    assign at_end         = (idx_reg == head.last_idx);
    assign m_valid        = head_valid;
    assign m_out_byte     = head.data[idx_reg];
    assign m_out_last     = at_end;
    assign m_out_file_end = at_end && head.file_end;
    assign pop            = head_valid && m_ready && at_end;

    always_comb begin
        idx_next = idx_reg;
        if (head_valid && m_ready) begin
            idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule
